/* design/gdbd_pkg.sv */
// ----------------------------------------------------------------------------
// gdbd_pkg - shared types, constants and calendar tables
// Widths, constant divisors and month tables used across the date pipeline.
// ----------------------------------------------------------------------------
package gdbd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;
  localparam int ORD_W   = 23;   // day ordinal, covers every 14-bit year
  localparam int Q100_W  = 8;    // year / 100 for a 14-bit year
  localparam int PARTB_W = 10;   // month offset + day + century term

  localparam logic [YEAR_W-1:0]  MAX_YEAR  = YEAR_W'(9999);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // y / 100 == (y * Q100_MUL) >> Q100_SHIFT, exact for y < 43690
  localparam int PROD_W     = 27;
  localparam int Q100_SHIFT = 19;
  localparam logic [PROD_W-1:0] Q100_MUL = PROD_W'(5243);

  localparam logic [YEAR_W-1:0] CENTURY    = YEAR_W'(100);
  localparam logic [ORD_W-1:0]  YEAR_DAYS  = ORD_W'(365);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  // per-stage load strobes of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } gdbd_adv_t;

  // checked date, handed from the year split to the ordinal stages
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  prev_year;   // year - 1
    logic [Q100_W-1:0]  prev_q100;   // (year - 1) / 100
    logic               leap;
    logic               ok;
  } gdbd_date_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  // days of a common year before the first of month m
  function automatic logic [PARTB_W-1:0] month_before(input logic [MONTH_W-1:0] m);
    logic [PARTB_W-1:0] n;
    case (m)
      4'd1:    n = PARTB_W'(0);
      4'd2:    n = PARTB_W'(31);
      4'd3:    n = PARTB_W'(59);
      4'd4:    n = PARTB_W'(90);
      4'd5:    n = PARTB_W'(120);
      4'd6:    n = PARTB_W'(151);
      4'd7:    n = PARTB_W'(181);
      4'd8:    n = PARTB_W'(212);
      4'd9:    n = PARTB_W'(243);
      4'd10:   n = PARTB_W'(273);
      4'd11:   n = PARTB_W'(304);
      4'd12:   n = PARTB_W'(334);
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

/* design/gdbd_year_split.sv */
// ----------------------------------------------------------------------------
// gdbd_year_split - century split, leap test and date check (stages 1-2)
// Stage 1 forms year / 100 by reciprocal multiply; stage 2 derives the
// remainder, leap flag, (year-1)/100 and the validity of the date.
// ----------------------------------------------------------------------------
module gdbd_year_split (
  input  logic                          clk,
  input  gdbd_pkg::gdbd_adv_t           adv,
  input  logic [gdbd_pkg::DAY_W-1:0]    day,
  input  logic [gdbd_pkg::MONTH_W-1:0]  month,
  input  logic [gdbd_pkg::YEAR_W-1:0]   year,
  output gdbd_pkg::gdbd_date_t          date
);

  logic [gdbd_pkg::DAY_W-1:0]   s1_day;
  logic [gdbd_pkg::MONTH_W-1:0] s1_month;
  logic [gdbd_pkg::YEAR_W-1:0]  s1_year;
  logic [gdbd_pkg::Q100_W-1:0]  s1_q100;
  logic [gdbd_pkg::PROD_W-1:0]  prod;

  logic [gdbd_pkg::YEAR_W-1:0]  rem;
  logic                         rem_zero;
  logic                         leap;
  logic                         ok;
  logic [gdbd_pkg::DAY_W-1:0]   len;
  gdbd_pkg::gdbd_date_t         date_next;

  assign prod = gdbd_pkg::PROD_W'(year) * gdbd_pkg::Q100_MUL;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1_day   <= day;
      s1_month <= month;
      s1_year  <= year;
      s1_q100  <= prod[gdbd_pkg::Q100_SHIFT +: gdbd_pkg::Q100_W];
    end
  end

  always_comb begin
    rem      = s1_year - gdbd_pkg::YEAR_W'(s1_q100) * gdbd_pkg::CENTURY;
    rem_zero = (rem == '0);
    // div by 4 and not 100, or div by 400 (century count div by 4)
    leap     = ((s1_year[1:0] == 2'b00) && !rem_zero) ||
               (rem_zero && (s1_q100[1:0] == 2'b00));
    len      = gdbd_pkg::month_len(s1_month, leap);
    ok       = (s1_year != '0) && (s1_year <= gdbd_pkg::MAX_YEAR) &&
               (s1_month >= gdbd_pkg::MONTH_JAN) && (s1_month <= gdbd_pkg::MONTH_DEC) &&
               (s1_day != '0) && (s1_day <= len);
    date_next.day       = s1_day;
    date_next.month     = s1_month;
    date_next.prev_year = s1_year - gdbd_pkg::YEAR_W'(1);
    // floor((y-1)/100) drops by one exactly when y is a multiple of 100
    date_next.prev_q100 = s1_q100 - gdbd_pkg::Q100_W'(rem_zero);
    date_next.leap      = leap;
    date_next.ok        = ok;
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      date <= date_next;
    end
  end

endmodule

/* design/gdbd_ordinal.sv */
// ----------------------------------------------------------------------------
// gdbd_ordinal - day ordinal of a checked date (stages 3-4)
// Stage 3 forms 365*p + p/4 and the month, day and p/400 terms; stage 4 sums them
// and subtracts the century count.
// ----------------------------------------------------------------------------
module gdbd_ordinal (
  input  logic                        clk,
  input  gdbd_pkg::gdbd_adv_t         adv,
  input  gdbd_pkg::gdbd_date_t        date,
  output logic [gdbd_pkg::ORD_W-1:0]  ordinal,
  output logic                        ok
);

  logic [gdbd_pkg::ORD_W-1:0]   part_a;
  logic [gdbd_pkg::PARTB_W-1:0] part_b;
  logic [gdbd_pkg::Q100_W-1:0]  q100;
  logic                         s3_ok;
  logic [gdbd_pkg::ORD_W-1:0]   part_a_next;
  logic [gdbd_pkg::PARTB_W-1:0] part_b_next;
  logic                         past_feb;

  always_comb begin
    past_feb    = (date.month > gdbd_pkg::MONTH_FEB) && date.leap;
    part_a_next = gdbd_pkg::ORD_W'(date.prev_year) * gdbd_pkg::YEAR_DAYS +
                  gdbd_pkg::ORD_W'(date.prev_year >> 2);
    part_b_next = gdbd_pkg::month_before(date.month) +
                  gdbd_pkg::PARTB_W'(past_feb) +
                  gdbd_pkg::PARTB_W'(date.day) +
                  gdbd_pkg::PARTB_W'(date.prev_q100 >> 2);
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      part_a <= part_a_next;
      part_b <= part_b_next;
      q100   <= date.prev_q100;
      s3_ok  <= date.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      ordinal <= part_a + gdbd_pkg::ORD_W'(part_b) - gdbd_pkg::ORD_W'(q100);
      ok      <= s3_ok;
    end
  end

endmodule

/* design/gregorian_days_between_dates.sv */
// ----------------------------------------------------------------------------
// gregorian_days_between_dates - day count between two Gregorian dates
// Takes a pair of (day, month, year) dates per transaction, checks each
// against the Gregorian calendar (years 1..9999, leap February), and returns
// the absolute number of days between them, both validity flags and whether
// the second date is the later one. A new transaction may enter every cycle
// while date_stall is low; it passes five register stages, the first loading
// at the accepting edge and the last being the output register. The five
// stages are: year/100 by reciprocal multiply; leap test and date check;
// 365-day multiply with month and day terms; the ordinal sum; and the
// absolute difference with saturation. Stalls on the result side hold the
// pipeline; bubbles close up so that the input keeps accepting while any
// stage is empty. day_count is 0 when either date is invalid, and
// second_is_later always compares the raw fields.
// ----------------------------------------------------------------------------
module gregorian_days_between_dates (
  input  logic                          clk,
  input  logic                          rst,
  // date pair transactions
  input  logic                          date_valid,
  output logic                          date_stall,
  input  logic [gdbd_pkg::DAY_W-1:0]    first_day,
  input  logic [gdbd_pkg::MONTH_W-1:0]  first_month,
  input  logic [gdbd_pkg::YEAR_W-1:0]   first_year,
  input  logic [gdbd_pkg::DAY_W-1:0]    second_day,
  input  logic [gdbd_pkg::MONTH_W-1:0]  second_month,
  input  logic [gdbd_pkg::YEAR_W-1:0]   second_year,
  // result transactions
  output logic                          count_valid,
  input  logic                          count_stall,
  output logic [gdbd_pkg::COUNT_W-1:0]  day_count,
  output logic                          first_ok,
  output logic                          second_ok,
  output logic                          second_is_later
);

  // stage valid bits; v5 is the output register
  logic v1, v2, v3, v4, v5;
  gdbd_pkg::gdbd_adv_t adv;

  // second_is_later travels alongside the datapath
  logic later1, later2, later3, later4;

  gdbd_pkg::gdbd_date_t       date_a, date_b;
  logic [gdbd_pkg::ORD_W-1:0] ord_a, ord_b;
  logic                       ok_a, ok_b;

  logic [gdbd_pkg::ORD_W-1:0] diff;

  // A stage loads when it is empty or the stage after it is moving.
  always_comb begin
    adv.s5 = !v5 || !count_stall;
    adv.s4 = !v4 || adv.s5;
    adv.s3 = !v3 || adv.s4;
    adv.s2 = !v2 || adv.s3;
    adv.s1 = !v1 || adv.s2;
  end

  assign date_stall = !adv.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv.s1) v1 <= date_valid;
      if (adv.s2) v2 <= v1;
      if (adv.s3) v3 <= v2;
      if (adv.s4) v4 <= v3;
      if (adv.s5) v5 <= v4;
    end
  end

  // raw lexicographic compare of (year, month, day)
  always_ff @(posedge clk) begin
    if (adv.s1) later1 <= {second_year, second_month, second_day} >
                          {first_year, first_month, first_day};
    if (adv.s2) later2 <= later1;
    if (adv.s3) later3 <= later2;
    if (adv.s4) later4 <= later3;
  end

  gdbd_year_split u_split_a (
    .clk   (clk),
    .adv   (adv),
    .day   (first_day),
    .month (first_month),
    .year  (first_year),
    .date  (date_a)
  );

  gdbd_year_split u_split_b (
    .clk   (clk),
    .adv   (adv),
    .day   (second_day),
    .month (second_month),
    .year  (second_year),
    .date  (date_b)
  );

  gdbd_ordinal u_ord_a (
    .clk     (clk),
    .adv     (adv),
    .date    (date_a),
    .ordinal (ord_a),
    .ok      (ok_a)
  );

  gdbd_ordinal u_ord_b (
    .clk     (clk),
    .adv     (adv),
    .date    (date_b),
    .ordinal (ord_b),
    .ok      (ok_b)
  );

  // stage 5: absolute difference, saturated to the count width
  assign diff = (ord_a > ord_b) ? (ord_a - ord_b) : (ord_b - ord_a);

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      first_ok        <= ok_a;
      second_ok       <= ok_b;
      second_is_later <= later4;
      if (!(ok_a && ok_b)) begin
        day_count <= '0;
      end else if (diff > gdbd_pkg::ORD_W'(gdbd_pkg::COUNT_MAX)) begin
        day_count <= gdbd_pkg::COUNT_MAX;
      end else begin
        day_count <= diff[gdbd_pkg::COUNT_W-1:0];
      end
    end
  end

  assign count_valid = v5;

endmodule

/* design/gdbd_checker.sv */
// ----------------------------------------------------------------------------
// gdbd_checker - port-level checks for the day count block
// Watches the result channel for hold behavior and count consistency.
// ----------------------------------------------------------------------------
module gdbd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          count_valid,
  input logic                          count_stall,
  input logic [gdbd_pkg::COUNT_W-1:0]  day_count,
  input logic                          first_ok,
  input logic                          second_ok,
  input logic                          second_is_later
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    count_valid && count_stall |=> count_valid)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    count_valid && count_stall |=> $stable(day_count) && $stable(first_ok) &&
                                   $stable(second_ok) && $stable(second_is_later))
    else $error("result payload changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    count_valid && (!first_ok || !second_ok) |-> day_count == '0)
    else $error("nonzero count with an invalid date");

  a_later_nonzero: assert property (@(posedge clk) disable iff (rst)
    count_valid && first_ok && second_ok && second_is_later |-> day_count != '0)
    else $error("distinct valid dates gave a zero count");

endmodule

bind gregorian_days_between_dates gdbd_checker u_gdbd_checker (
  .clk             (clk),
  .rst             (rst),
  .count_valid     (count_valid),
  .count_stall     (count_stall),
  .day_count       (day_count),
  .first_ok        (first_ok),
  .second_ok       (second_ok),
  .second_is_later (second_is_later)
);

/* tb/gregorian_days_between_dates_tb.sv */
// ----------------------------------------------------------------------------
// gregorian_days_between_dates_tb - self-checking bench for the date span unit
// Sends date pairs through the valid/stall handshake and checks each returned
// day count, both validity flags and the ordering bit against a calendar
// model computed in the bench. Directed corner dates run first, then random
// pairs, a long hold-off on the result side, and a burst with no idle cycles.
// ----------------------------------------------------------------------------
module gregorian_days_between_dates_tb;
  import gdbd_pkg::*;

  // the pipeline is five stages deep; allow some margin when draining
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 120;
  localparam int MAX_REPORTS  = 10;

  localparam int unsigned DAYS_IN_MONTH [1:12] = '{31, 28, 31, 30, 31, 30,
                                                   31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [COUNT_W-1:0] days;
    logic               first_valid;
    logic               second_valid;
    logic               second_after;
  } span_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 date_valid = 1'b0;
  logic                 date_stall;
  logic [DAY_W-1:0]     first_day = '0;
  logic [MONTH_W-1:0]   first_month = '0;
  logic [YEAR_W-1:0]    first_year = '0;
  logic [DAY_W-1:0]     second_day = '0;
  logic [MONTH_W-1:0]   second_month = '0;
  logic [YEAR_W-1:0]    second_year = '0;
  logic                 count_valid;
  logic                 count_stall = 1'b0;
  logic [COUNT_W-1:0]   day_count;
  logic                 first_ok;
  logic                 second_ok;
  logic                 second_is_later;

  span_t expected_spans[$];   // predicted results, oldest first
  int    fail_count = 0;

  // idling control: no_idle turns off random gaps and stalls on both sides;
  // a hold request makes the result side stall, counting hold_left down from HOLD_CYCLES
  bit    no_idle = 1'b0;
  int    hold_asks = 0;
  int    hold_served = 0;
  int    hold_left = 0;
  int    stall_run_left = 0;
  bit    stall_run_on = 1'b0;

  gregorian_days_between_dates uut (
    .clk             (clk),
    .rst             (rst),
    .date_valid      (date_valid),
    .date_stall      (date_stall),
    .first_day       (first_day),
    .first_month     (first_month),
    .first_year      (first_year),
    .second_day      (second_day),
    .second_month    (second_month),
    .second_year     (second_year),
    .count_valid     (count_valid),
    .count_stall     (count_stall),
    .day_count       (day_count),
    .first_ok        (first_ok),
    .second_ok       (second_ok),
    .second_is_later (second_is_later)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Calendar model
  // --------------------------------------------------------------------------
  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in(int unsigned m, int unsigned y);
    if (m == MONTH_FEB && leap_year(y)) return 29;
    return DAYS_IN_MONTH[m];
  endfunction

  function automatic bit calendar_ok(int unsigned d, int unsigned m, int unsigned y);
    if (y < 1 || y > MAX_YEAR) return 1'b0;
    if (m < MONTH_JAN || m > MONTH_DEC) return 1'b0;
    return d >= 1 && d <= days_in(m, y);
  endfunction

  // days since a fixed epoch; only differences matter
  function automatic int unsigned day_number(int unsigned d, int unsigned m,
                                             int unsigned y);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int k = MONTH_JAN; k < m; k++) n += DAYS_IN_MONTH[k];
    if (m > MONTH_FEB && leap_year(y)) n++;
    return n + d;
  endfunction

  function automatic span_t predict_span(
    logic [DAY_W-1:0] d1, logic [MONTH_W-1:0] m1, logic [YEAR_W-1:0] y1,
    logic [DAY_W-1:0] d2, logic [MONTH_W-1:0] m2, logic [YEAR_W-1:0] y2);
    span_t       r;
    int unsigned a;
    int unsigned b;
    int unsigned gap;
    r.first_valid  = calendar_ok(d1, m1, y1);
    r.second_valid = calendar_ok(d2, m2, y2);
    // ordering uses the raw fields, valid or not
    r.second_after = (y2 > y1) || (y2 == y1 && m2 > m1) ||
                     (y2 == y1 && m2 == m1 && d2 > d1);
    r.days = '0;
    if (r.first_valid && r.second_valid) begin
      a = day_number(d1, m1, y1);
      b = day_number(d2, m2, y2);
      gap = (a > b) ? a - b : b - a;
      r.days = (gap > COUNT_MAX) ? COUNT_MAX : COUNT_W'(gap);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Idle lengths: mostly short, now and then long
  // --------------------------------------------------------------------------
  function automatic int sender_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one date pair per call. Valid stays high between back-to-back
  // transactions so it is never dropped and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic send_pair(
    input logic [DAY_W-1:0] d1, input logic [MONTH_W-1:0] m1,
    input logic [YEAR_W-1:0] y1,
    input logic [DAY_W-1:0] d2, input logic [MONTH_W-1:0] m2,
    input logic [YEAR_W-1:0] y2);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      date_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    date_valid   <= 1'b1;
    first_day    <= d1;
    first_month  <= m1;
    first_year   <= y1;
    second_day   <= d2;
    second_month <= m2;
    second_year  <= y2;
    do @(posedge clk); while (date_stall);
    expected_spans.push_back(predict_span(d1, m1, y1, d2, m2, y2));
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus the long hold-off when asked for
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left == 0 && hold_served != hold_asks) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      count_stall <= 1'b1;
    end else if (no_idle) begin
      count_stall <= 1'b0;
    end else begin
      if (stall_run_left == 0) begin
        stall_run_on   = ($urandom_range(0, 2) == 0);
        stall_run_left = stall_run_on ? stall_len() : $urandom_range(1, 12);
      end
      stall_run_left--;
      count_stall <= stall_run_on;
    end
  end

  // check every accepted result against the oldest prediction
  always @(posedge clk) begin
    span_t want;
    if (!rst && count_valid && !count_stall) begin
      if (expected_spans.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: count=%0d ok=%b/%b later=%b",
                   day_count, first_ok, second_ok, second_is_later);
      end else begin
        want = expected_spans.pop_front();
        if (day_count !== want.days || first_ok !== want.first_valid ||
            second_ok !== want.second_valid ||
            second_is_later !== want.second_after) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: expected count=%0d ok=%b/%b later=%b, got count=%0d ok=%b/%b later=%b",
                     want.days, want.first_valid, want.second_valid,
                     want.second_after, day_count, first_ok, second_ok,
                     second_is_later);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Random dates
  // --------------------------------------------------------------------------
  function automatic logic [YEAR_W-1:0] pick_year();
    int roll;
    int y;
    roll = $urandom_range(0, 99);
    if (roll < 40) return YEAR_W'($urandom_range(1, 9999));
    if (roll < 60) begin
      // around century years, where the leap rule bends
      y = 100 * $urandom_range(1, 99) + $urandom_range(0, 5) - 1;
      return YEAR_W'(y);
    end
    if (roll < 80) return YEAR_W'($urandom_range(1, 30));
    return YEAR_W'($urandom_range(9970, 9999));
  endfunction

  task automatic pick_date(output logic [DAY_W-1:0] d, output logic [MONTH_W-1:0] m,
                           output logic [YEAR_W-1:0] y);
    int roll;
    roll = $urandom_range(0, 99);
    y = pick_year();
    m = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
    if (roll < 70) begin
      d = DAY_W'($urandom_range(1, days_in(m, y)));
    end else if (roll < 82) begin
      // just past the month end, day zero, or a leap day in any year
      case ($urandom_range(0, 2))
        0: d = DAY_W'(days_in(m, y) + 1);
        1: d = '0;
        default: begin
          m = MONTH_FEB;
          d = DAY_W'(29);
        end
      endcase
    end else if (roll < 90) begin
      d = DAY_W'($urandom_range(1, 28));
      y = ($urandom_range(0, 1) == 0) ? '0 : YEAR_W'($urandom_range(10000, 16383));
    end else begin
      d = DAY_W'($urandom);
      m = MONTH_W'($urandom);
      y = YEAR_W'($urandom);
    end
  endtask

  task automatic send_random_pair();
    logic [DAY_W-1:0]   d1, d2;
    logic [MONTH_W-1:0] m1, m2;
    logic [YEAR_W-1:0]  y1, y2;
    pick_date(d1, m1, y1);
    pick_date(d2, m2, y2);
    case ($urandom_range(0, 7))
      0: begin   // same date
        d2 = d1; m2 = m1; y2 = y1;
      end
      1: begin   // same year, sometimes same month
        y2 = y1;
        if ($urandom_range(0, 1) == 0) m2 = m1;
      end
      default: ;
    endcase
    send_pair(d1, m1, y1, d2, m2, y2);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    send_pair(5'd1,  4'd1,  14'd2000, 5'd1,  4'd1,  14'd2000);  // equal dates
    send_pair(5'd1,  4'd1,  14'd1,    5'd31, 4'd12, 14'd9999);  // widest span
    send_pair(5'd31, 4'd12, 14'd9999, 5'd1,  4'd1,  14'd1);     // reversed
    send_pair(5'd28, 4'd2,  14'd2023, 5'd1,  4'd3,  14'd2023);  // one day
    send_pair(5'd29, 4'd2,  14'd2000, 5'd1,  4'd3,  14'd2000);  // leap by 400
    send_pair(5'd29, 4'd2,  14'd1900, 5'd1,  4'd3,  14'd1900);  // century, no leap
    send_pair(5'd29, 4'd2,  14'd2024, 5'd29, 4'd2,  14'd2023);  // leap / common
    send_pair(5'd1,  4'd1,  14'd0,    5'd1,  4'd1,  14'd1);     // year zero
    send_pair(5'd1,  4'd1,  14'd9999, 5'd1,  4'd1,  14'd10000); // past top year
    send_pair(5'd31, 4'd15, 14'd16383, 5'd0, 4'd0,  14'd16383); // field maxima
    send_pair(5'd0,  4'd5,  14'd1234, 5'd31, 4'd4,  14'd1234);  // day 0, April 31
    send_pair(5'd10, 4'd0,  14'd500,  5'd10, 4'd13, 14'd500);   // bad months
    send_pair(5'd31, 4'd12, 14'd1999, 5'd1,  4'd1,  14'd2000);  // year wrap
    // second day must be checked against its own month
    send_pair(5'd15, 4'd2,  14'd2021, 5'd31, 4'd1,  14'd2021);
    send_pair(5'd15, 4'd1,  14'd2021, 5'd31, 4'd4,  14'd2021);
    // ordering bit on invalid fields
    send_pair(5'd31, 4'd14, 14'd300,  5'd0,  4'd15, 14'd300);
    send_pair(5'd20, 4'd6,  14'd300,  5'd21, 4'd6,  14'd300);
    send_pair(5'd31, 4'd1,  14'd1,    5'd1,  4'd1,  14'd1);
    send_pair(5'd31, 4'd10, 14'd1600, 5'd31, 4'd12, 14'd1700);
    send_pair(5'd30, 4'd11, 14'd9999, 5'd1,  4'd6,  14'd400);
  endtask

  task automatic test_random_pairs(input int n);
    repeat (n) send_random_pair();
  endtask

  // result side holds off while pairs keep coming, so the pipe fills and
  // date_stall has to rise
  task automatic test_back_pressure();
    no_idle = 1'b1;
    hold_asks++;
    repeat (40) send_random_pair();
    no_idle = 1'b0;
  endtask

  // full rate both ways
  task automatic test_full_rate(input int n);
    no_idle = 1'b1;
    repeat (n) send_random_pair();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_pairs(600);
    test_back_pressure();
    test_full_rate(300);
    test_random_pairs(650);
    date_valid <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("gregorian_days_between_dates_tb: clean");
    end else begin
      $display("gregorian_days_between_dates_tb: errors");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("gregorian_days_between_dates_tb: errors");
    $finish;
  end

endmodule

/* sim.f */
design/gdbd_pkg.sv
design/gdbd_year_split.sv
design/gdbd_ordinal.sv
design/gregorian_days_between_dates.sv
design/gdbd_checker.sv
tb/gregorian_days_between_dates_tb.sv
